// ----- hdl/tcw_pkg.sv -----
// Shared types, constants and tables for the text console writer.
// No dependencies; every other file of the block imports this package.
package tcw_pkg;

    // Screen geometry and tab spacing
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int TAB_W  = $clog2(COLUMNS + TAB_STOP);

    // Fixed widths of the port fields
    localparam int OP_W         = 2;
    localparam int CHAR_W       = 8;
    localparam int RD_ROW_W     = 5;
    localparam int RD_COL_W     = 7;
    localparam int OUT_ROW_W    = 5;
    localparam int OUT_COL_W    = 7;
    localparam int OUT_LINEAR_W = 11;
    localparam int CELL_W       = 16;
    localparam int COLOR_W      = 4;
    localparam int CFG_IDX_W    = 1;

    // Character codes and cell constants
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h0F;
    localparam logic [COLOR_W-1:0] FG_RESET    = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET    = 4'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CHAR,
        WR_FILL,
        WR_INIT
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_CELL,
        RD_COPY
    } rd_sel_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_HOME
    } cur_op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    capture;
        cur_op_t cur_op;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        ptr_op_t ptr_op;
        logic    out_load;
    } tcw_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic is_print;
        logic scroll;
        logic ptr_copy_last;
        logic ptr_last;
    } tcw_stat_t;

    // Next tab stop for every column, built without division
    typedef logic [TAB_W-1:0] tab_tbl_t [COLUMNS];

    function automatic tab_tbl_t build_tab_tbl();
        tab_tbl_t    t;
        int unsigned m;
        m = TAB_STOP;
        for (int i = 0; i < COLUMNS; i++) begin
            if (i >= m) begin
                m = m + TAB_STOP;
            end
            t[i] = TAB_W'(m);
        end
        return t;
    endfunction

    localparam tab_tbl_t TAB_NEXT = build_tab_tbl();

endpackage

// ----- hdl/text_console_writer_unit.sv -----
// Top level of the text console writer: controller plus datapath.
// Each transaction passes dispatch and done states; the next waits for done,
// which holds while a result is stalled. A scroll adds a copy of CELLS - COLUMNS
// cells, a drain state and a blank of COLUMNS cells; a clear blanks CELLS cells.
// Reset (aresetn low, synchronous) homes the cursor, restores the colors and
// starts a clearing pass over CELLS cells; s_ready stays low until it ends.
module text_console_writer_unit
    import tcw_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [COLOR_W-1:0]      cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_operation,
    input  logic [CHAR_W-1:0]       s_char_byte,
    input  logic [RD_ROW_W-1:0]     s_read_row,
    input  logic [RD_COL_W-1:0]     s_read_column,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OUT_ROW_W-1:0]    m_cursor_row,
    output logic [OUT_COL_W-1:0]    m_cursor_column,
    output logic [OUT_LINEAR_W-1:0] m_cursor_linear,
    output logic [CELL_W-1:0]       m_cell_data,
    output logic                    m_did_scroll
);

    tcw_cmd_t  cmd;
    tcw_stat_t stat;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcw_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_operation     (s_operation),
        .s_char_byte     (s_char_byte),
        .s_read_row      (s_read_row),
        .s_read_column   (s_read_column),
        .cmd             (cmd),
        .stat            (stat),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_column (m_cursor_column),
        .m_cursor_linear (m_cursor_linear),
        .m_cell_data     (m_cell_data),
        .m_did_scroll    (m_did_scroll)
    );

endmodule

// ----- hdl/tcw_ctrl.sv -----
// Controller state machine of the text console writer.
// Sequences reset clearing, character writes, scrolls, clears and reads.
// Depends on tcw_pkg.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  tcw_stat_t stat,
    output tcw_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.cur_op   = CUR_HOLD;
        cmd.wr_sel   = WR_NONE;
        cmd.rd_sel   = RD_NONE;
        cmd.ptr_op   = PTR_HOLD;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.wr_sel = WR_INIT;
                if (stat.ptr_last) begin
                    cmd.ptr_op = PTR_ZERO;
                    state_next = ST_IDLE;
                end else begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.op)
                    OP_WRITE: begin
                        cmd.cur_op = CUR_ADVANCE;
                        if (stat.is_print) begin
                            cmd.wr_sel = WR_CHAR;
                        end
                        if (stat.scroll) begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = ST_COPY;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.cur_op = CUR_HOME;
                        cmd.ptr_op = PTR_ZERO;
                        state_next = ST_FILL;
                    end
                    OP_READ: begin
                        cmd.rd_sel = RD_CELL;
                        state_next = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_COPY: begin
                // move one row up, one cell per cycle
                cmd.rd_sel = RD_COPY;
                cmd.ptr_op = PTR_INC;
                if (stat.ptr_copy_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last copy write lands this cycle
                state_next = ST_FILL;
            end
            ST_FILL: begin
                cmd.wr_sel = WR_FILL;
                if (stat.ptr_last) begin
                    cmd.ptr_op = PTR_ZERO;
                    state_next = ST_DONE;
                end else begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the consumer takes it
    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ----- hdl/tcw_datapath.sv -----
// Datapath of the text console writer: screen memory, cursor, colors,
// sweep pointer and result register. Depends on tcw_pkg.
module tcw_datapath
    import tcw_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [COLOR_W-1:0]      cfg_wr_data,
    input  logic [OP_W-1:0]         s_operation,
    input  logic [CHAR_W-1:0]       s_char_byte,
    input  logic [RD_ROW_W-1:0]     s_read_row,
    input  logic [RD_COL_W-1:0]     s_read_column,
    input  tcw_cmd_t                cmd,
    output tcw_stat_t               stat,
    output logic [OUT_ROW_W-1:0]    m_cursor_row,
    output logic [OUT_COL_W-1:0]    m_cursor_column,
    output logic [OUT_LINEAR_W-1:0] m_cursor_linear,
    output logic [CELL_W-1:0]       m_cell_data,
    output logic                    m_did_scroll
);

    logic [CELL_W-1:0]       mem [CELLS];
    logic [CELL_W-1:0]       rd_data_reg;
    logic                    copy_pend_reg;

    logic [COLOR_W-1:0]      fg_reg;
    logic [COLOR_W-1:0]      bg_reg;
    op_t                     op_reg;
    logic [CHAR_W-1:0]       ch_reg;
    logic [RD_ROW_W-1:0]     rr_reg;
    logic [RD_COL_W-1:0]     rc_reg;
    logic                    scroll_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        col_reg;
    logic [ADDR_W-1:0]       ptr_reg;

    logic [OUT_ROW_W-1:0]    out_row_reg;
    logic [OUT_COL_W-1:0]    out_col_reg;
    logic [OUT_LINEAR_W-1:0] out_linear_reg;
    logic [CELL_W-1:0]       out_cell_reg;
    logic                    out_scroll_reg;

    logic [CHAR_W-1:0]       attr;
    logic [ADDR_W-1:0]       cur_addr;
    logic [ADDR_W-1:0]       cell_addr;
    logic                    cell_in_range;
    logic [ROW_W:0]          nrow;
    logic [COL_W-1:0]        ncol;
    logic                    nscroll;
    logic                    is_print;
    logic [TAB_W-1:0]        tab_col;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [CELL_W-1:0]       wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;

    assign attr     = {bg_reg, fg_reg};
    assign cur_addr = ADDR_W'(32'(row_reg) * COLUMNS + 32'(col_reg));

    // Address of the cell asked for by a read
    assign cell_in_range = (32'(rr_reg) < ROWS) && (32'(rc_reg) < COLUMNS);
    assign cell_addr     = cell_in_range ?
                           ADDR_W'(32'(rr_reg) * COLUMNS + 32'(rc_reg)) : '0;

    // Cursor movement for the captured character
    assign tab_col = TAB_NEXT[col_reg];

    always_comb begin
        nrow     = {1'b0, row_reg};
        ncol     = col_reg;
        nscroll  = 1'b0;
        is_print = 1'b0;
        case (ch_reg)
            CH_BACKSPACE: begin
                if (col_reg != '0) begin
                    ncol = col_reg - 1'b1;
                end else if (row_reg != '0) begin
                    nrow = {1'b0, row_reg} - 1'b1;
                    ncol = COL_W'(COLUMNS - 1);
                end
            end
            CH_TAB: begin
                if (32'(tab_col) >= COLUMNS) begin
                    ncol = '0;
                    nrow = {1'b0, row_reg} + 1'b1;
                end else begin
                    ncol = COL_W'(tab_col);
                end
            end
            CH_RETURN: begin
                ncol = '0;
            end
            CH_NEWLINE: begin
                ncol = '0;
                nrow = {1'b0, row_reg} + 1'b1;
            end
            default: begin
                is_print = 1'b1;
                if (32'(col_reg) == COLUMNS - 1) begin
                    ncol = '0;
                    nrow = {1'b0, row_reg} + 1'b1;
                end else begin
                    ncol = col_reg + 1'b1;
                end
            end
        endcase
        // pin the cursor to the bottom row when the screen scrolls
        if (32'(nrow) >= ROWS) begin
            nscroll = 1'b1;
            nrow    = (ROW_W + 1)'(ROWS - 1);
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_FOREGROUND: fg_reg <= cfg_wr_data;
                CFG_BACKGROUND: bg_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= op_t'(s_operation);
            ch_reg <= s_char_byte;
            rr_reg <= s_read_row;
            rc_reg <= s_read_column;
        end
    end

    // Cursor, scroll flag and sweep pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg    <= '0;
            col_reg    <= '0;
            ptr_reg    <= '0;
            scroll_reg <= 1'b0;
        end else begin
            case (cmd.cur_op)
                CUR_ADVANCE: begin
                    row_reg <= ROW_W'(nrow);
                    col_reg <= ncol;
                end
                CUR_HOME: begin
                    row_reg <= '0;
                    col_reg <= '0;
                end
                default: begin
                end
            endcase
            if (cmd.capture) begin
                scroll_reg <= 1'b0;
            end else if (cmd.cur_op == CUR_ADVANCE) begin
                scroll_reg <= nscroll;
            end
            case (cmd.ptr_op)
                PTR_ZERO: ptr_reg <= '0;
                PTR_INC:  ptr_reg <= ptr_reg + 1'b1;
                default: begin
                end
            endcase
        end
    end

    // Select the memory write: a pending copy first, else the command
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = {BLANK_CHAR, BLANK_CHAR};
        if (copy_pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = ptr_reg - 1'b1;
            wr_data = rd_data_reg;
        end else begin
            case (cmd.wr_sel)
                WR_CHAR: begin
                    wr_en   = 1'b1;
                    wr_addr = cur_addr;
                    wr_data = {attr, ch_reg};
                end
                WR_FILL: begin
                    wr_en   = 1'b1;
                    wr_data = {attr, BLANK_CHAR};
                end
                WR_INIT: begin
                    wr_en   = 1'b1;
                    wr_data = {RESET_ATTR, BLANK_CHAR};
                end
                default: begin
                end
            endcase
        end
    end

    // Select the memory read
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = cell_addr;
        case (cmd.rd_sel)
            RD_CELL: begin
                rd_en = 1'b1;
            end
            RD_COPY: begin
                rd_en   = 1'b1;
                rd_addr = ptr_reg + ADDR_W'(COLUMNS);
            end
            default: begin
            end
        endcase
    end

    // Screen memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Copy write follows its read in the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            copy_pend_reg <= 1'b0;
        end else begin
            copy_pend_reg <= (cmd.rd_sel == RD_COPY);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_row_reg    <= OUT_ROW_W'(32'(row_reg));
            out_col_reg    <= OUT_COL_W'(32'(col_reg));
            out_linear_reg <= OUT_LINEAR_W'(32'(row_reg) * COLUMNS + 32'(col_reg));
            out_cell_reg   <= (op_reg == OP_READ && cell_in_range) ? rd_data_reg : '0;
            out_scroll_reg <= scroll_reg;
        end
    end

    assign stat.op            = op_reg;
    assign stat.is_print      = is_print;
    assign stat.scroll        = nscroll;
    assign stat.ptr_copy_last = (32'(ptr_reg) == CELLS - COLUMNS - 1);
    assign stat.ptr_last      = (32'(ptr_reg) == CELLS - 1);

    assign m_cursor_row    = out_row_reg;
    assign m_cursor_column = out_col_reg;
    assign m_cursor_linear = out_linear_reg;
    assign m_cell_data     = out_cell_reg;
    assign m_did_scroll    = out_scroll_reg;

endmodule

// ----- hdl/tcw_checker.sv -----
// Port-level checks of the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_unit.
module tcw_checker
    import tcw_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [OUT_ROW_W-1:0]    m_cursor_row,
    input logic [OUT_COL_W-1:0]    m_cursor_column,
    input logic [OUT_LINEAR_W-1:0] m_cursor_linear,
    input logic [CELL_W-1:0]       m_cell_data,
    input logic                    m_did_scroll
);

    // Reset starts the clearing pass: no input taken, no result shown
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready or valid high right after reset");

    // A stalled result stays valid and keeps its linear cursor, cell data and scroll flag
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_linear)
            && $stable(m_cell_data) && $stable(m_did_scroll))
        else $error("result changed while stalled");

    // Linear cursor agrees with row and column
    a_linear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cursor_linear ==
            OUT_LINEAR_W'(32'(m_cursor_row) * COLUMNS + 32'(m_cursor_column)))
        else $error("linear cursor mismatch");

    // Cursor stays on screen
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_cursor_column) < COLUMNS) && (32'(m_cursor_row) < ROWS))
        else $error("cursor off screen");

    // A scroll leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_did_scroll |-> 32'(m_cursor_row) == ROWS - 1)
        else $error("scroll without cursor on bottom row");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);

// ----- bench/text_console_writer_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_unit: directed table plus random bursts.
// Depends on tcw_pkg and the unit; predicts reports from a shadow screen unless typed.
module text_console_writer_unit_tb;
    import tcw_pkg::*;

    localparam int DIRECTED_N = 24;
    localparam int PHASES     = 4;
    localparam int PHASE_ITEMS = 30;

    typedef struct packed {
        op_t                  op;
        logic [CHAR_W-1:0]    ch;
        logic [RD_ROW_W-1:0]  read_row;
        logic [RD_COL_W-1:0]  read_col;
    } console_cmd_t;

    typedef struct packed {
        logic [OUT_ROW_W-1:0]    row;
        logic [OUT_COL_W-1:0]    col;
        logic [OUT_LINEAR_W-1:0] linear;
        logic [CELL_W-1:0]       cell_data;
        logic                    scroll;
    } cursor_report_t;

    typedef struct packed {
        console_cmd_t   cmd;
        logic           typed;
        cursor_report_t want;
    } console_vector_t;

    typedef enum int {
        BK_TEXT,
        BK_NEWLINES,
        BK_TABS,
        BK_BACKS,
        BK_READS,
        BK_CLEAR,
        BK_NOP
    } burst_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_wr_index;
    logic [COLOR_W-1:0]      cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [OP_W-1:0]         s_operation;
    logic [CHAR_W-1:0]       s_char_byte;
    logic [RD_ROW_W-1:0]     s_read_row;
    logic [RD_COL_W-1:0]     s_read_column;
    logic                    m_valid;
    logic                    m_ready;
    logic [OUT_ROW_W-1:0]    m_cursor_row;
    logic [OUT_COL_W-1:0]    m_cursor_column;
    logic [OUT_LINEAR_W-1:0] m_cursor_linear;
    logic [CELL_W-1:0]       m_cell_data;
    logic                    m_did_scroll;

    // Shadow of the console state
    logic [CELL_W-1:0]  shadow_screen [CELLS];
    int unsigned        shadow_row;
    int unsigned        shadow_col;
    logic [COLOR_W-1:0] shadow_fg;
    logic [COLOR_W-1:0] shadow_bg;

    cursor_report_t  expected_reports [$];
    console_vector_t directed_tbl [DIRECTED_N];
    logic            cmd_typed;
    cursor_report_t  cmd_want;
    int              fail_count;
    int              items_sent;
    int              results_seen;

    logic [COLOR_W-1:0] phase_fg [PHASES] = '{4'd0, 4'd7, 4'd15, 4'd0};
    logic [COLOR_W-1:0] phase_bg [PHASES] = '{4'd15, 4'd9, 4'd15, 4'd0};

    text_console_writer_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_char_byte     (s_char_byte),
        .s_read_row      (s_read_row),
        .s_read_column   (s_read_column),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_column (m_cursor_column),
        .m_cursor_linear (m_cursor_linear),
        .m_cell_data     (m_cell_data),
        .m_did_scroll    (m_did_scroll)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Blank cell in the current colors
    function automatic logic [CELL_W-1:0] blank_cell();
        return {shadow_bg, shadow_fg, BLANK_CHAR};
    endfunction

    // Apply one command to the shadow console and report the cursor
    function automatic cursor_report_t console_apply(console_cmd_t c);
        cursor_report_t r;
        logic           back;
        logic [CELL_W-1:0] cell_val;
        back     = 1'b0;
        cell_val = '0;
        r        = '0;
        case (c.op)
            OP_WRITE: begin
                if (c.ch == CH_BACKSPACE) begin
                    back = 1'b1;
                end else if (c.ch == CH_TAB) begin
                    shadow_col = shadow_col + TAB_STOP - (shadow_col % TAB_STOP);
                end else if (c.ch == CH_RETURN) begin
                    shadow_col = 0;
                end else if (c.ch == CH_NEWLINE) begin
                    shadow_col = 0;
                    shadow_row = shadow_row + 1;
                end else begin
                    shadow_screen[shadow_row * COLUMNS + shadow_col] =
                        {shadow_bg, shadow_fg, c.ch};
                    shadow_col = shadow_col + 1;
                end
                // Backspace crosses to the end of the previous row, never past home
                if (back) begin
                    if (shadow_col > 0) begin
                        shadow_col = shadow_col - 1;
                    end else if (shadow_row > 0) begin
                        shadow_row = shadow_row - 1;
                        shadow_col = COLUMNS - 1;
                    end
                end
                if (shadow_col >= COLUMNS) begin
                    shadow_col = 0;
                    shadow_row = shadow_row + 1;
                end
                // Scroll up one row and blank the bottom row
                if (shadow_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++) begin
                        shadow_screen[i] = shadow_screen[i + COLUMNS];
                    end
                    for (int j = 0; j < COLUMNS; j++) begin
                        shadow_screen[(ROWS - 1) * COLUMNS + j] = blank_cell();
                    end
                    shadow_row = ROWS - 1;
                    r.scroll   = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    shadow_screen[i] = blank_cell();
                end
                shadow_row = 0;
                shadow_col = 0;
            end
            OP_READ: begin
                if (c.read_row < ROWS && c.read_col < COLUMNS) begin
                    cell_val = shadow_screen[c.read_row * COLUMNS + c.read_col];
                end
            end
            default: begin
            end
        endcase
        r.row       = OUT_ROW_W'(shadow_row);
        r.col       = OUT_COL_W'(shadow_col);
        r.linear    = OUT_LINEAR_W'(shadow_row * COLUMNS + shadow_col);
        r.cell_data = cell_val;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Track config writes, predict on input transactions, check output transactions
    always @(posedge aclk) begin
        cursor_report_t got;
        cursor_report_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) begin
                shadow_screen[i] = {RESET_ATTR, BLANK_CHAR};
            end
            shadow_row = 0;
            shadow_col = 0;
            shadow_fg  = FG_RESET;
            shadow_bg  = BG_RESET;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == CFG_FOREGROUND) begin
                    shadow_fg = cfg_wr_data;
                end else if (cfg_wr_index == CFG_BACKGROUND) begin
                    shadow_bg = cfg_wr_data;
                end
            end
            if (s_valid && s_ready) begin
                want = console_apply('{op_t'(s_operation), s_char_byte,
                                       s_read_row, s_read_column});
                if (cmd_typed) begin
                    want = cmd_want;
                end
                expected_reports.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = '{m_cursor_row, m_cursor_column, m_cursor_linear,
                        m_cell_data, m_did_scroll};
                if (expected_reports.size() == 0) begin
                    $error("unexpected result transaction: row %0d column %0d",
                           got.row, got.col);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("cursor_row", want.row, got.row);
                    check_field("cursor_column", want.col, got.col);
                    check_field("cursor_linear", want.linear, got.linear);
                    check_field("cell_data", want.cell_data, got.cell_data);
                    check_field("did_scroll", want.scroll, got.scroll);
                end
                results_seen++;
            end
        end
    end

    // Idle length: mostly short, sometimes long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: stretches of ready broken by random stalls
    initial begin
        int unsigned n;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            n = gap_len();
            if (n != 0) begin
                m_ready <= 1'b0;
                repeat (n - 1) @(posedge aclk);
            end
        end
    end

    // Present one command and hold it until accepted; entered and left on a clock edge
    task automatic send_cmd(input console_cmd_t c, input logic typed,
                            input cursor_report_t want, input bit eager);
        int unsigned g;
        g = eager ? 0 : gap_len();
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_operation   <= c.op;
        s_char_byte   <= c.ch;
        s_read_row    <= c.read_row;
        s_read_column <= c.read_col;
        cmd_typed     <= typed;
        cmd_want      <= want;
        s_valid       <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding report has come back
    task automatic wait_reports_in();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_seen < items_sent) @(posedge aclk);
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_FOREGROUND;
        cfg_wr_data  <= fg;
        @(posedge aclk);
        cfg_wr_index <= CFG_BACKGROUND;
        cfg_wr_data  <= bg;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    function automatic console_cmd_t random_cmd(input burst_t kind);
        console_cmd_t c;
        c.op       = OP_WRITE;
        c.ch       = CHAR_W'($urandom_range(0, 255));
        c.read_row = RD_ROW_W'($urandom_range(0, 31));
        c.read_col = RD_COL_W'($urandom_range(0, 127));
        case (kind)
            BK_TEXT: begin
                if ($urandom_range(0, 9) == 0) c.ch = CH_NEWLINE;
            end
            BK_NEWLINES: c.ch = CH_NEWLINE;
            BK_TABS: c.ch = ($urandom_range(0, 3) == 0) ? CH_RETURN : CH_TAB;
            BK_BACKS: c.ch = CH_BACKSPACE;
            BK_READS: begin
                c.op = OP_READ;
                // Mostly cells on screen, the rest drawn over the whole field range
                if ($urandom_range(0, 3) != 0) begin
                    c.read_row = RD_ROW_W'($urandom_range(0, ROWS - 1));
                    c.read_col = RD_COL_W'($urandom_range(0, COLUMNS - 1));
                end
            end
            BK_CLEAR: c.op = OP_CLEAR;
            default: c.op = OP_NONE;
        endcase
        return c;
    endfunction

    // Stimulus
    initial begin
        int unsigned   r;
        int unsigned   len;
        int            phase_items;
        bit            eager;
        bit            paused;
        burst_t        kind;
        console_cmd_t  c;

        // Directed rows: typed reports where obvious, the predictor elsewhere
        directed_tbl = '{
            '{'{OP_READ,  8'h00, 5'd0,  7'd0},   1'b1, '{5'd0, 7'd0, 11'd0, 16'h0F20, 1'b0}},
            '{'{OP_WRITE, CH_BACKSPACE, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd0, 11'd0, 16'h0, 1'b0}},
            '{'{OP_NONE,  8'hFF, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 11'd0, 16'h0, 1'b0}},
            '{'{OP_READ,  8'h00, 5'd24, 7'd79},  1'b1, '{5'd0, 7'd0, 11'd0, 16'h0F20, 1'b0}},
            '{'{OP_READ,  8'h00, 5'd25, 7'd0},   1'b1, '{5'd0, 7'd0, 11'd0, 16'h0, 1'b0}},
            '{'{OP_READ,  8'h00, 5'd0,  7'd80},  1'b1, '{5'd0, 7'd0, 11'd0, 16'h0, 1'b0}},
            '{'{OP_READ,  8'hFF, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 11'd0, 16'h0, 1'b0}},
            '{'{OP_WRITE, 8'h41, 5'd0,  7'd0},   1'b0, '0},
            '{'{OP_WRITE, 8'hFF, 5'd0,  7'd0},   1'b0, '0},
            '{'{OP_WRITE, 8'h00, 5'd0,  7'd0},   1'b0, '0},
            '{'{OP_WRITE, 8'h80, 5'd0,  7'd0},   1'b0, '0},
            '{'{OP_READ,  8'h00, 5'd0,  7'd1},   1'b0, '0},
            '{'{OP_WRITE, CH_TAB, 5'd0, 7'd0},   1'b0, '0},
            '{'{OP_WRITE, CH_TAB, 5'd0, 7'd0},   1'b0, '0},
            '{'{OP_WRITE, CH_RETURN, 5'd0, 7'd0},    1'b0, '0},
            '{'{OP_WRITE, CH_NEWLINE, 5'd0, 7'd0},   1'b0, '0},
            '{'{OP_WRITE, CH_BACKSPACE, 5'd0, 7'd0}, 1'b0, '0},
            '{'{OP_WRITE, 8'h5A, 5'd0,  7'd0},   1'b0, '0},
            '{'{OP_WRITE, CH_BACKSPACE, 5'd0, 7'd0}, 1'b0, '0},
            '{'{OP_WRITE, CH_TAB, 5'd0, 7'd0},   1'b0, '0},
            '{'{OP_READ,  8'h00, 5'd0,  7'd79},  1'b0, '0},
            '{'{OP_CLEAR, 8'h00, 5'd0,  7'd0},   1'b1, '{5'd0, 7'd0, 11'd0, 16'h0, 1'b0}},
            '{'{OP_READ,  8'h00, 5'd0,  7'd0},   1'b1, '{5'd0, 7'd0, 11'd0, 16'h0F20, 1'b0}},
            '{'{OP_WRITE, 8'h7F, 5'd0,  7'd0},   1'b0, '0}
        };

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = CFG_FOREGROUND;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_operation   = OP_NONE;
        s_char_byte   = '0;
        s_read_row    = '0;
        s_read_column = '0;
        cmd_typed     = 1'b0;
        cmd_want      = '0;
        fail_count    = 0;
        items_sent    = 0;
        results_seen  = 0;
        paused        = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++) begin
            send_cmd(directed_tbl[i].cmd, directed_tbl[i].typed, directed_tbl[i].want, 1'b0);
        end

        // Random bursts, one color setting per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_reports_in();
            set_colors(phase_fg[ph], phase_bg[ph]);
            phase_items = 0;
            // Push the cursor off the bottom row early on
            if (ph == 0) begin
                len = $urandom_range(ROWS, ROWS + 5);
                for (int k = 0; k < len; k++) begin
                    send_cmd(random_cmd(BK_NEWLINES), 1'b0, '0, 1'b0);
                    phase_items++;
                end
            end
            while (phase_items < PHASE_ITEMS) begin
                r     = $urandom_range(0, 99);
                eager = ($urandom_range(0, 3) == 0);
                if (r < 40) begin
                    kind = BK_TEXT;
                    len  = $urandom_range(1, 20);
                end else if (r < 55) begin
                    kind = BK_NEWLINES;
                    len  = $urandom_range(1, 12);
                end else if (r < 65) begin
                    kind = BK_TABS;
                    len  = $urandom_range(1, 12);
                end else if (r < 75) begin
                    kind = BK_BACKS;
                    len  = $urandom_range(1, 10);
                end else if (r < 90) begin
                    kind = BK_READS;
                    len  = $urandom_range(1, 4);
                end else if (r < 93) begin
                    kind = BK_CLEAR;
                    len  = 1;
                end else begin
                    kind = BK_NOP;
                    len  = $urandom_range(1, 3);
                end
                for (int k = 0; k < len; k++) begin
                    c = random_cmd(kind);
                    send_cmd(c, 1'b0, '0, eager);
                    if (c.op != OP_NONE) phase_items++;
                end
                // Hold the sender once mid-phase until the unit has answered everything
                if (ph == 2 && !paused && phase_items >= PHASE_ITEMS / 2) begin
                    wait_reports_in();
                    paused = 1'b1;
                end
            end
        end

        wait_reports_in();
        repeat (16) @(posedge aclk);
        if (expected_reports.size() != 0) begin
            $error("%0d expected reports never arrived", expected_reports.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("text_console_writer_unit_tb passed");
        end else begin
            $display("text_console_writer_unit_tb failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("text_console_writer_unit_tb failed");
        $finish;
    end

endmodule
